// ----- hw/rtl/xoshiro_random_generator_core_macros.svh -----
// Assertion macros for the xoshiro generator core.
// Used by the top level only; needs a clock named i_clk and reset i_rst_n in scope.
`ifndef XOSHIRO_RANDOM_GENERATOR_CORE_MACROS_SVH
`define XOSHIRO_RANDOM_GENERATOR_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define XRG_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define XRG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/xrg_pkg.sv -----
// Package for the xoshiro generator core: operation codes and fixed constants.
// No dependencies.
package xrg_pkg;

    // Operation codes carried on the func field
    localparam logic [1:0] FUNC_RESEED = 2'd0;
    localparam logic [1:0] FUNC_RAW    = 2'd1;
    localparam logic [1:0] FUNC_RAW31  = 2'd2;
    localparam logic [1:0] FUNC_RANGED = 2'd3;

    // Seed expansion and state update constants
    localparam logic [31:0] GEN_MULT = 32'h6c07_8965;
    localparam int unsigned SEED_SHIFT = 30;
    localparam int unsigned UPD_ROT = 11;
    localparam logic [31:0] JUMP_WORDS [4] = '{
        32'h8764_000b, 32'hf542_d2d3, 32'h6fa0_35c3, 32'h77f2_db5b
    };

    // Divisor of the ranged draw, 2^32 - 1
    localparam logic [32:0] FULL_SCALE = 33'h0_ffff_ffff;

    typedef logic [31:0] t_word;

endpackage

// ----- hw/rtl/xoshiro_random_generator_core.sv -----
// Steps: raw draws pass the draw and done states, ranged draws pass draw, multiply,
// divide, fix and done, equal range ends pass draw and done; a reseed runs its seed steps.
// Flow: one item at a time; a draw frees the input only once its result is in the output
// register, a reseed once its steps are done; a ranged draw uses the shared
// 32x32 multiplier once, a reseed three times (one step per cycle).
// Reset: synchronous, active low; afterward the core expands seed zero in three steps
// and holds in_ready low until that is done.
`include "xoshiro_random_generator_core_macros.svh"

module xoshiro_random_generator_core
    import xrg_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_func,
    input  logic [31:0]        i_seed,
    input  logic signed [31:0] i_range_low,
    input  logic signed [31:0] i_range_high,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [32:0] o_value
);

    // Sequencer states
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SEED = 3'd1;
    localparam logic [2:0] ST_DRAW = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_DIV  = 3'd4;
    localparam logic [2:0] ST_FIX  = 3'd5;
    localparam logic [2:0] ST_DONE = 3'd6;

    logic [2:0]         r_state;
    logic [1:0]         r_cnt;
    t_word              r_words [4];
    logic [1:0]         r_func;
    logic [31:0]        r_lo;
    logic [31:0]        r_hi;
    t_word              r_rnd;
    logic [31:0]        r_mag;
    logic               r_neg;
    logic [63:0]        r_prod;
    logic [31:0]        r_quo;
    logic               r_rem_nz;
    logic [32:0]        r_res;
    logic               r_ovalid;
    logic [32:0]        r_oval;

    // Shared multiplier and its operand select
    t_word              w_mul_a;
    t_word              w_mul_b;
    logic [63:0]        w_prod;

    // Seed step
    t_word              w_prev;
    t_word              w_seed_word;

    // Scrambler and state update
    t_word              w_x5;
    t_word              w_rot;
    t_word              w_scr;
    t_word              w_t;
    t_word              w_w2n;
    t_word              w_w3n;
    t_word              w_w1n;
    t_word              w_w0n;

    // Range span
    logic [32:0]        w_span;
    logic [32:0]        w_span_abs;

    // Division by 2^32 - 1
    logic [32:0]        w_sum;
    logic               w_ge;
    logic [32:0]        w_rem;

    // Final offset and truncation toward zero
    logic [34:0]        w_lo35;
    logic [34:0]        w_q35;
    logic [34:0]        w_base;
    logic [34:0]        w_adj;

    logic               w_out_free;
    logic               w_load;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_value     = r_oval;
    assign w_out_free  = !r_ovalid || i_out_ready;
    assign w_load      = (r_state == ST_DONE) && w_out_free;

    // Select multiplier operands: seed expansion or ranged scaling
    assign w_prev  = r_words[r_cnt - 2'd1];
    assign w_mul_a = (r_state == ST_SEED) ? w_prev : r_rnd;
    assign w_mul_b = (r_state == ST_SEED) ? GEN_MULT : r_mag;
    assign w_prod  = {32'd0, w_mul_a} * {32'd0, w_mul_b};

    // One seed expansion step
    assign w_seed_word = w_prod[31:0]
                       ^ ({30'd0, w_prev[31:SEED_SHIFT]} + {30'd0, r_cnt})
                       ^ JUMP_WORDS[r_cnt];

    // Scramble word 0: rotl(w0 * 5, 7) * 9
    assign w_x5  = r_words[0] + {r_words[0][29:0], 2'b00};
    assign w_rot = {w_x5[24:0], w_x5[31:25]};
    assign w_scr = w_rot + {w_rot[28:0], 3'b000};

    // Advance the four words
    assign w_t   = {r_words[1][22:0], 9'd0};
    assign w_w2n = r_words[2] ^ r_words[0];
    assign w_w3n = r_words[3] ^ r_words[1];
    assign w_w1n = r_words[1] ^ w_w2n;
    assign w_w0n = r_words[0] ^ w_w3n;

    // Span of the range and its magnitude
    assign w_span     = {r_hi[31], r_hi} - {r_lo[31], r_lo};
    assign w_span_abs = w_span[32] ? (33'd0 - w_span) : w_span;

    // prod = H*2^32 + L = H*(2^32-1) + (H + L); H + L stays below twice the divisor
    assign w_sum = {1'b0, r_prod[63:32]} + {1'b0, r_prod[31:0]};
    assign w_ge  = (w_sum >= FULL_SCALE);
    assign w_rem = w_ge ? (w_sum - FULL_SCALE) : w_sum;

    // Offset from the lower end, then round toward zero
    assign w_lo35 = {{3{r_lo[31]}}, r_lo};
    assign w_q35  = {3'd0, r_quo};
    assign w_base = r_neg ? (w_lo35 - w_q35) : (w_lo35 + w_q35);

    always_comb begin
        w_adj = w_base;
        if (r_rem_nz) begin
            if (!r_neg && w_base[34]) begin
                w_adj = w_base + 35'd1;
            end else if (r_neg && !w_base[34] && (w_base != 35'd0)) begin
                w_adj = w_base - 35'd1;
            end
        end
    end

    // Load the output item when a result is done, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_load) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    // Sequencer, word state and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_SEED;
            r_cnt      <= 2'd1;
            r_words[0] <= JUMP_WORDS[0];
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_func <= i_func;
                        r_lo   <= i_range_low;
                        r_hi   <= i_range_high;
                        if (i_func == FUNC_RESEED) begin
                            r_words[0] <= i_seed ^ JUMP_WORDS[0];
                            r_cnt      <= 2'd1;
                            r_state    <= ST_SEED;
                        end else begin
                            r_state <= ST_DRAW;
                        end
                    end
                end
                ST_SEED: begin
                    r_words[r_cnt] <= w_seed_word;
                    if (r_cnt == 2'd3) begin
                        r_cnt   <= 2'd0;
                        r_state <= ST_IDLE;
                    end else begin
                        r_cnt <= r_cnt + 2'd1;
                    end
                end
                ST_DRAW: begin
                    if (r_func == FUNC_RANGED && r_lo == r_hi) begin
                        // Equal ends: return the lower end, hold the generator
                        r_res   <= {r_lo[31], r_lo};
                        r_state <= ST_DONE;
                    end else begin
                        r_rnd      <= w_scr;
                        r_words[0] <= w_w0n;
                        r_words[1] <= w_w1n;
                        r_words[2] <= w_w2n ^ w_t;
                        r_words[3] <= {w_w3n[31-UPD_ROT:0], w_w3n[31:32-UPD_ROT]};
                        r_mag      <= w_span_abs[31:0];
                        r_neg      <= w_span[32];
                        if (r_func == FUNC_RAW31) begin
                            r_res   <= {2'b00, w_scr[31:1]};
                            r_state <= ST_DONE;
                        end else if (r_func == FUNC_RAW) begin
                            r_res   <= {1'b0, w_scr};
                            r_state <= ST_DONE;
                        end else begin
                            r_state <= ST_MUL;
                        end
                    end
                end
                ST_MUL: begin
                    r_prod  <= w_prod;
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    r_quo    <= r_prod[63:32] + {31'd0, w_ge};
                    r_rem_nz <= (w_rem != 33'd0);
                    r_state  <= ST_FIX;
                end
                ST_FIX: begin
                    r_res   <= w_adj[32:0];
                    r_state <= ST_DONE;
                end
                ST_DONE: begin
                    // Hand the result to the output register when it is free
                    if (w_out_free) begin
                        r_oval  <= r_res;
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Seed expansion ends after its third step
    `XRG_ASSERT_NEXT(a_seed_end, r_state == ST_SEED && r_cnt == 2'd3, r_state == ST_IDLE, "seed run")
    // Ranged scaling runs multiply then divide
    `XRG_ASSERT_NEXT(a_mul_div, r_state == ST_MUL, r_state == ST_DIV, "multiply without divide")
    // A finished item reaches the output register when it is free
    `XRG_ASSERT_NEXT(a_done_out, w_load, o_out_valid && r_state == ST_IDLE, "result not loaded")
    // No new items are taken while seeding; only the idle state takes them
    `XRG_ASSERT_NOW(a_seed_busy, r_state == ST_SEED, !o_in_ready, "input ready during seeding")

endmodule
